>>> src/clrl_pkg.sv
// shared types, codes and constants of the command admission rate limiter
package clrl_pkg;

    localparam int PLAYER_SLOTS = 16;
    localparam int SLOT_W = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
    localparam int CNT_W = $clog2(PLAYER_SLOTS + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W = 16;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 32;
    localparam int SCALE_W = 10;
    localparam int PROD_W = COUNT_W + SCALE_W;
    localparam int LIMIT_W = 2 * CFG_W;

    localparam logic [SCALE_W-1:0] RATE_SCALE = 10'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FUTURE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS = 2'd3;

    localparam logic [CFG_W-1:0] RST_MAX_PAST = 16'd60;
    localparam logic [CFG_W-1:0] RST_MAX_FUTURE = 16'd10;
    localparam logic [CFG_W-1:0] RST_MAX_RATE = 16'd60;
    localparam logic [CFG_W-1:0] RST_WINDOW_MS = 16'd1000;

    localparam logic [1:0] OP_VALIDATE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_RESET_STATS = 2'd2;

    localparam logic [2:0] STATUS_VALID = 3'd0;
    localparam logic [2:0] STATUS_NO_PLAYER = 3'd1;
    localparam logic [2:0] STATUS_TOO_OLD = 3'd2;
    localparam logic [2:0] STATUS_TOO_FUTURE = 3'd3;
    localparam logic [2:0] STATUS_RATE_LIMITED = 3'd4;
    localparam logic [2:0] STATUS_MALFORMED = 3'd5;
    localparam logic [2:0] STATUS_TABLE_FULL = 3'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic        well_formed;
        logic        player_present;
        logic [63:0] key_upper;
        logic [63:0] key_lower;
        logic [63:0] command_tick;
        logic [63:0] current_tick;
        logic [63:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [COUNT_W-1:0] player_window_count;
        logic [TOTAL_W-1:0] total_seen;
        logic [TOTAL_W-1:0] total_rejected;
    } rsp_t;

    typedef struct packed {
        logic [63:0]        key_upper;
        logic [63:0]        key_lower;
        logic [63:0]        window_start;
        logic [COUNT_W-1:0] window_count;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic bound;
        logic check;
        logic search_step;
        logic update;
        logic limit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       early;
        logic       search_done;
        logic       out_free;
    } ctrl_sts_t;

endpackage

>>> src/command_admission_rate_limiter_core.sv
// top level of the command admission rate limiter
//
// cmd channel (cmd_valid/cmd_ready/cmd_data) takes one transaction at a time:
// validate a command, clear one player's slot, or reset the totals.
// rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one result per
// transaction, in order: status, player window count and saturating totals.
// cfg_we/cfg_index/cfg_wdata write the four limits; write only while idle.
// steps from cmd acceptance to rsp_valid, by controller state:
//   validate with early reject (malformed, no player, tick window): bound,
//   check, finish; validate reaching the limiter: bound, check, search,
//   update, limit, finish; clear entry: bound, search, finish; reset totals
//   or unused op: bound, finish.
// the slot search reads one table entry per cycle from a single ram port;
// cmd_ready returns in the cycle rsp_valid rises.
// reset clears the slot valid bits, totals and limits to their defaults;
// the slot ram itself is not cleared.
// the result sits in an output register; a new transaction is accepted while
// it waits, and the next result holds in its last step until the slot frees.
module command_admission_rate_limiter_core import clrl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    clrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    clrl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

>>> src/clrl_ram.sv
// generic single write port ram with registered read
module clrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/clrl_ctrl.sv
// controller state machine sequencing one transaction through the datapath
module clrl_ctrl import clrl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BOUND = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_LIMIT = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.latch = 1'b1;
                    state_next = S_BOUND;
                end
            end
            S_BOUND:
            begin
                ctl.bound = 1'b1;
                if (sts.operation == OP_VALIDATE)
                begin
                    state_next = S_CHECK;
                end
                else if (sts.operation == OP_CLEAR)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CHECK:
            begin
                ctl.check = 1'b1;
                state_next = sts.early ? S_FINISH : S_SEARCH;
            end
            S_SEARCH:
            begin
                ctl.search_step = 1'b1;
                if (sts.search_done)
                begin
                    state_next = (sts.operation == OP_VALIDATE) ? S_UPDATE : S_FINISH;
                end
            end
            S_UPDATE:
            begin
                ctl.update = 1'b1;
                state_next = S_LIMIT;
            end
            S_LIMIT:
            begin
                ctl.limit = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/clrl_datapath.sv
// datapath: config registers, tick checks, slot search, window update and totals
module clrl_datapath import clrl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  ctrl_cmd_t            ctl,
    output ctrl_sts_t            sts,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp_data
);

    // configuration
    logic [CFG_W-1:0] max_past_reg;
    logic [CFG_W-1:0] max_future_reg;
    logic [CFG_W-1:0] max_rate_reg;
    logic [CFG_W-1:0] window_ms_reg;

    // transaction payload and intermediate results
    cmd_t               in_reg;
    logic [63:0]        lower_reg;
    logic [63:0]        upper_reg;
    logic [LIMIT_W-1:0] rate_lim_reg;
    logic               early_reg;
    logic [2:0]         early_status_reg;

    // slot search
    logic [PLAYER_SLOTS-1:0] used_reg;
    logic [CNT_W-1:0]        addr_cnt_reg;
    logic [SLOT_W-1:0]       pend_idx_reg;
    logic                    pend_vld_reg;
    logic                    hit_reg;
    logic [SLOT_W-1:0]       hit_idx_reg;
    logic [63:0]             hit_start_reg;
    logic [COUNT_W-1:0]      hit_count_reg;
    logic                    free_found_reg;
    logic [SLOT_W-1:0]       free_idx_reg;

    // window update
    logic               full_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [63:0]        start_new_reg;
    logic [COUNT_W-1:0] cnt_new_reg;
    logic [PROD_W-1:0]  prod_reg;

    // totals and result
    logic [TOTAL_W-1:0] seen_reg;
    logic [TOTAL_W-1:0] rejected_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_data_reg;

    entry_t rd_entry;
    entry_t wr_entry;
    logic   ram_we;

    logic        early;
    logic [2:0]  early_status;
    logic [64:0] upper_sum;
    logic        key_match;

    logic [63:0]        base_start;
    logic [COUNT_W-1:0] base_count;
    logic [63:0]        win_diff;
    logic               new_window;
    logic [COUNT_W-1:0] win_count;

    logic               is_validate;
    logic [2:0]         fin_status;
    logic [COUNT_W-1:0] fin_count;
    logic [TOTAL_W-1:0] seen_next;
    logic [TOTAL_W-1:0] rejected_next;

    clrl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (PLAYER_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (wr_entry),
        .raddr (addr_cnt_reg[SLOT_W-1:0]),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_past_reg <= RST_MAX_PAST;
            max_future_reg <= RST_MAX_FUTURE;
            max_rate_reg <= RST_MAX_RATE;
            window_ms_reg <= RST_WINDOW_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_PAST: max_past_reg <= cfg_wdata;
                CFG_MAX_FUTURE: max_future_reg <= cfg_wdata;
                CFG_MAX_RATE: max_rate_reg <= cfg_wdata;
                CFG_WINDOW_MS: window_ms_reg <= cfg_wdata;
                default: max_past_reg <= max_past_reg;
            endcase
        end
    end

    // early checks
    assign upper_sum = {1'b0, in_reg.current_tick} + {49'd0, max_future_reg};

    always_comb
    begin
        early = 1'b1;
        early_status = STATUS_VALID;
        if (!in_reg.well_formed)
        begin
            early_status = STATUS_MALFORMED;
        end
        else if (!in_reg.player_present)
        begin
            early_status = STATUS_NO_PLAYER;
        end
        else if (in_reg.command_tick < lower_reg)
        begin
            early_status = STATUS_TOO_OLD;
        end
        else if (in_reg.command_tick > upper_reg)
        begin
            early_status = STATUS_TOO_FUTURE;
        end
        else
        begin
            early = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            in_reg <= cmd_data;
        end
        if (ctl.bound)
        begin
            if (in_reg.current_tick >= {48'd0, max_past_reg})
            begin
                lower_reg <= in_reg.current_tick - {48'd0, max_past_reg};
            end
            else
            begin
                lower_reg <= '0;
            end
            upper_reg <= upper_sum[64] ? '1 : upper_sum[63:0];
            rate_lim_reg <= LIMIT_W'(max_rate_reg) * LIMIT_W'(window_ms_reg);
        end
        if (ctl.check)
        begin
            early_status_reg <= early_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            early_reg <= 1'b0;
        end
        else if (ctl.bound)
        begin
            early_reg <= 1'b0;
        end
        else if (ctl.check)
        begin
            early_reg <= early;
        end
    end

    // slot search, one ram read issued and one entry compared per cycle
    assign key_match = pend_vld_reg && used_reg[pend_idx_reg]
                       && (rd_entry.key_upper == in_reg.key_upper)
                       && (rd_entry.key_lower == in_reg.key_lower);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_cnt_reg <= '0;
            pend_vld_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.bound)
        begin
            addr_cnt_reg <= '0;
            pend_vld_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.search_step)
        begin
            if (addr_cnt_reg < CNT_W'(PLAYER_SLOTS))
            begin
                addr_cnt_reg <= addr_cnt_reg + 1'b1;
                pend_vld_reg <= 1'b1;
            end
            else
            begin
                pend_vld_reg <= 1'b0;
            end
            if (key_match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (pend_vld_reg && !used_reg[pend_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.search_step)
        begin
            pend_idx_reg <= addr_cnt_reg[SLOT_W-1:0];
            if (key_match && !hit_reg)
            begin
                hit_idx_reg <= pend_idx_reg;
                hit_start_reg <= rd_entry.window_start;
                hit_count_reg <= rd_entry.window_count;
            end
            if (pend_vld_reg && !used_reg[pend_idx_reg] && !free_found_reg)
            begin
                free_idx_reg <= pend_idx_reg;
            end
        end
    end

    // window test
    assign base_start = hit_reg ? hit_start_reg : '0;
    assign base_count = hit_reg ? hit_count_reg : '0;
    assign win_diff = in_reg.now_ms - base_start;
    assign new_window = (win_diff >= {48'd0, window_ms_reg});
    assign win_count = new_window ? '0 : base_count;

    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            full_reg <= !hit_reg && !free_found_reg;
            slot_reg <= hit_reg ? hit_idx_reg : free_idx_reg;
            start_new_reg <= new_window ? in_reg.now_ms : base_start;
            cnt_new_reg <= (win_count != COUNT_MAX) ? win_count + 1'b1 : win_count;
        end
        if (ctl.limit)
        begin
            prod_reg <= PROD_W'(cnt_new_reg) * PROD_W'(RATE_SCALE);
        end
    end

    // completion
    assign is_validate = (in_reg.operation == OP_VALIDATE);

    always_comb
    begin
        fin_status = STATUS_VALID;
        fin_count = '0;
        if (is_validate)
        begin
            if (early_reg)
            begin
                fin_status = early_status_reg;
            end
            else if (full_reg)
            begin
                fin_status = STATUS_TABLE_FULL;
            end
            else
            begin
                fin_count = cnt_new_reg;
                if ({{(LIMIT_W - PROD_W){1'b0}}, prod_reg} > rate_lim_reg)
                begin
                    fin_status = STATUS_RATE_LIMITED;
                end
            end
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        rejected_next = rejected_reg;
        if (in_reg.operation == OP_RESET_STATS)
        begin
            seen_next = '0;
            rejected_next = '0;
        end
        else if (is_validate)
        begin
            if (seen_reg != TOTAL_MAX)
            begin
                seen_next = seen_reg + 1'b1;
            end
            if ((fin_status != STATUS_VALID) && (rejected_reg != TOTAL_MAX))
            begin
                rejected_next = rejected_reg + 1'b1;
            end
        end
    end

    assign ram_we = ctl.finish && is_validate && !early_reg && !full_reg;

    always_comb
    begin
        wr_entry.key_upper = in_reg.key_upper;
        wr_entry.key_lower = in_reg.key_lower;
        wr_entry.window_start = start_new_reg;
        wr_entry.window_count = cnt_new_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            seen_reg <= '0;
            rejected_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.finish)
            begin
                seen_reg <= seen_next;
                rejected_reg <= rejected_next;
                if (ram_we)
                begin
                    used_reg[slot_reg] <= 1'b1;
                end
                else if ((in_reg.operation == OP_CLEAR) && hit_reg)
                begin
                    used_reg[hit_idx_reg] <= 1'b0;
                end
            end
            if (ctl.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            rsp_data_reg.status <= fin_status;
            rsp_data_reg.player_window_count <= fin_count;
            rsp_data_reg.total_seen <= seen_next;
            rsp_data_reg.total_rejected <= rejected_next;
        end
    end

    assign sts.operation = in_reg.operation;
    assign sts.early = early;
    assign sts.search_done = (addr_cnt_reg == CNT_W'(PLAYER_SLOTS)) && !pend_vld_reg;
    assign sts.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data = rsp_data_reg;

endmodule

>>> test/command_admission_rate_limiter_core_tb.sv
// self-checking testbench for the command admission rate limiter core
module command_admission_rate_limiter_core_tb;
    import clrl_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int KEY_POOL = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 190;

    logic                 clk;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_ready;
    cmd_t                 cmd_data;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    command_admission_rate_limiter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // limits and player table as the block should hold them
    logic [CFG_W-1:0]   past_limit;
    logic [CFG_W-1:0]   future_limit;
    logic [CFG_W-1:0]   rate_limit;
    logic [CFG_W-1:0]   window_len;
    logic               slot_busy [PLAYER_SLOTS];
    logic [63:0]        key_hi [PLAYER_SLOTS];
    logic [63:0]        key_lo [PLAYER_SLOTS];
    logic [63:0]        win_start [PLAYER_SLOTS];
    logic [COUNT_W-1:0] win_count [PLAYER_SLOTS];
    logic [TOTAL_W-1:0] seen_total;
    logic [TOTAL_W-1:0] rejected_total;

    cmd_t pending_commands [$];
    rsp_t predicted_responses [$];

    logic [63:0] pool_hi [KEY_POOL];
    logic [63:0] pool_lo [KEY_POOL];
    logic [63:0] sim_clock;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          hold_requests;
    int          holds_served;
    int          hold_left;
    int          idle_cycles;
    int          fail_count;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int find_player(logic [63:0] ku, logic [63:0] kl);
        for (int i = 0; i < PLAYER_SLOTS; i++)
        begin
            if (slot_busy[i] && key_hi[i] == ku && key_lo[i] == kl)
                return i;
        end
        return -1;
    endfunction

    function automatic rsp_t predict_admission(cmd_t c);
        rsp_t        r;
        logic [63:0] lo_bound;
        logic [64:0] hi_sum;
        logic [63:0] hi_bound;
        int          s;
        r = '0;
        r.status = STATUS_VALID;
        case (c.operation)
            OP_VALIDATE:
            begin
                if (seen_total != TOTAL_MAX)
                    seen_total++;
                lo_bound = (c.current_tick >= 64'(past_limit)) ?
                           c.current_tick - 64'(past_limit) : 64'd0;
                hi_sum = {1'b0, c.current_tick} + 65'(future_limit);
                hi_bound = hi_sum[64] ? '1 : hi_sum[63:0];
                if (!c.well_formed)
                    r.status = STATUS_MALFORMED;
                else if (!c.player_present)
                    r.status = STATUS_NO_PLAYER;
                else if (c.command_tick < lo_bound)
                    r.status = STATUS_TOO_OLD;
                else if (c.command_tick > hi_bound)
                    r.status = STATUS_TOO_FUTURE;
                else
                begin
                    s = find_player(c.key_upper, c.key_lower);
                    if (s < 0)
                    begin
                        for (int i = PLAYER_SLOTS - 1; i >= 0; i--)
                        begin
                            if (!slot_busy[i])
                                s = i;
                        end
                        if (s >= 0)
                        begin
                            slot_busy[s] = 1'b1;
                            key_hi[s] = c.key_upper;
                            key_lo[s] = c.key_lower;
                            win_start[s] = '0;
                            win_count[s] = '0;
                        end
                    end
                    if (s < 0)
                        r.status = STATUS_TABLE_FULL;
                    else
                    begin
                        if (c.now_ms - win_start[s] >= 64'(window_len))
                        begin
                            win_start[s] = c.now_ms;
                            win_count[s] = '0;
                        end
                        if (win_count[s] != COUNT_MAX)
                            win_count[s]++;
                        r.player_window_count = win_count[s];
                        if (64'(win_count[s]) * 64'd1000 >
                            64'(rate_limit) * 64'(window_len))
                            r.status = STATUS_RATE_LIMITED;
                    end
                end
                if (r.status != STATUS_VALID && rejected_total != TOTAL_MAX)
                    rejected_total++;
            end
            OP_CLEAR:
            begin
                s = find_player(c.key_upper, c.key_lower);
                if (s >= 0)
                    slot_busy[s] = 1'b0;
            end
            OP_RESET_STATS:
            begin
                seen_total = '0;
                rejected_total = '0;
            end
            default:
            begin
            end
        endcase
        r.total_seen = seen_total;
        r.total_rejected = rejected_total;
        return r;
    endfunction

    function automatic cmd_t validate_cmd(int k, logic [63:0] ctick, logic [63:0] cur,
                                          logic [63:0] now);
        cmd_t c;
        c = '0;
        c.operation = OP_VALIDATE;
        c.well_formed = 1'b1;
        c.player_present = 1'b1;
        c.key_upper = pool_hi[k];
        c.key_lower = pool_lo[k];
        c.command_tick = ctick;
        c.current_tick = cur;
        c.now_ms = now;
        return c;
    endfunction

    function automatic cmd_t control_cmd(logic [1:0] op, logic [63:0] ku, logic [63:0] kl);
        cmd_t c;
        c = '0;
        c.operation = op;
        c.well_formed = 1'($urandom_range(0, 1));
        c.player_present = 1'($urandom_range(0, 1));
        c.key_upper = ku;
        c.key_lower = kl;
        c.command_tick = rand64();
        c.current_tick = rand64();
        c.now_ms = rand64();
        return c;
    endfunction

    function automatic cmd_t random_command();
        cmd_t        c;
        int          pick;
        int          k;
        int unsigned span;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, KEY_POOL - 1);
        case ($urandom_range(0, 19))
            0: sim_clock = rand64();
            1: sim_clock = sim_clock - 64'($urandom_range(0, 2 * window_len));
            2: sim_clock = sim_clock + 64'(window_len * $urandom_range(1, 3));
            default: sim_clock = sim_clock + 64'($urandom_range(0, window_len / 40 + 1));
        endcase
        c = validate_cmd(k, '0, '0, sim_clock);
        case ($urandom_range(0, 9))
            0, 1: c.current_tick = 64'($urandom_range(0, 70000));
            2: c.current_tick = '1 - 64'($urandom_range(0, 70000));
            default: c.current_tick = rand64();
        endcase
        span = $urandom_range(0, past_limit + future_limit + 4);
        if ($urandom_range(0, 4) == 0)
            c.command_tick = rand64();
        else
            c.command_tick = c.current_tick + 64'(span) - 64'(past_limit) - 64'd2;
        if (pick < 3)
        begin
            // fresh player key that later clears can still find
            k = $urandom_range(6, KEY_POOL - 1);
            pool_hi[k] = rand64();
            pool_lo[k] = rand64();
            c.key_upper = pool_hi[k];
            c.key_lower = pool_lo[k];
        end
        else if (pick < 7)
        begin
            c.well_formed = 1'b0;
            c.player_present = 1'($urandom_range(0, 1));
        end
        else if (pick < 11)
            c.player_present = 1'b0;
        else if (pick < 19)
            c = control_cmd(OP_CLEAR, pool_hi[k], pool_lo[k]);
        else if (pick < 22)
            c = control_cmd(OP_RESET_STATS, rand64(), rand64());
        else if (pick < 24)
            c = control_cmd(OP_UNUSED, pool_hi[k], pool_lo[k]);
        return c;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (pending_commands.size() != 0 || cmd_valid || predicted_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic apply_limits(logic [CFG_W-1:0] past, logic [CFG_W-1:0] fut,
                                logic [CFG_W-1:0] rate, logic [CFG_W-1:0] win);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_PAST;
        cfg_wdata <= past;
        past_limit = past;
        @(posedge clk);
        cfg_index <= CFG_MAX_FUTURE;
        cfg_wdata <= fut;
        future_limit = fut;
        @(posedge clk);
        cfg_index <= CFG_MAX_RATE;
        cfg_wdata <= rate;
        rate_limit = rate;
        @(posedge clk);
        cfg_index <= CFG_WINDOW_MS;
        cfg_wdata <= win;
        window_len = win;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int unsigned send_pct, int unsigned stall_pct, bit sweep);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        if (sweep)
        begin
            for (int i = 0; i < PLAYER_SLOTS; i++)
            begin
                if (slot_busy[i])
                    pending_commands.push_back(control_cmd(OP_CLEAR, key_hi[i], key_lo[i]));
            end
        end
        for (int i = 0; i < PHASE_ITEMS; i++)
            pending_commands.push_back(random_command());
        wait_drained();
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // command sender
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            if (cmd_valid && cmd_ready)
                predicted_responses.push_back(predict_admission(cmd_data));
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd_data <= pending_commands.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // response receiver with random stalls and long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (predicted_responses.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual status %0d",
                         $time, rsp_data.status);
                fail_count++;
            end
            else
            begin
                rsp_t want;
                want = predicted_responses.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_data.status));
                check_field("player_window_count", 32'(want.player_window_count),
                            32'(rsp_data.player_window_count));
                check_field("total_seen", want.total_seen, rsp_data.total_seen);
                check_field("total_rejected", want.total_rejected, rsp_data.total_rejected);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_data <= '0;
        rsp_ready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_MAX_PAST;
        cfg_wdata <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        holds_served = 0;
        hold_left = 0;
        idle_cycles = 0;
        fail_count = 0;
        sim_clock = '0;
        past_limit = RST_MAX_PAST;
        future_limit = RST_MAX_FUTURE;
        rate_limit = RST_MAX_RATE;
        window_len = RST_WINDOW_MS;
        seen_total = '0;
        rejected_total = '0;
        for (int i = 0; i < PLAYER_SLOTS; i++)
            slot_busy[i] = 1'b0;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
        end
        // zero key, all-ones key, and pairs sharing one half of the key
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[3] = pool_hi[2];
        pool_lo[5] = pool_lo[4];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed checks at the reset limits
        @(negedge clk);
        pending_commands.push_back(validate_cmd(2, 64'd1000, 64'd1000, 64'd5));
        pending_commands[0].well_formed = 1'b0;
        pending_commands.push_back(validate_cmd(2, 64'd1000, 64'd1000, 64'd5));
        pending_commands[1].player_present = 1'b0;
        pending_commands.push_back(validate_cmd(2, 64'd939, 64'd1000, 64'd5));
        pending_commands.push_back(validate_cmd(2, 64'd1011, 64'd1000, 64'd5));
        pending_commands.push_back(validate_cmd(2, 64'd940, 64'd1000, 64'd5));
        pending_commands.push_back(validate_cmd(2, 64'd1010, 64'd1000, 64'd999));
        pending_commands.push_back(validate_cmd(2, 64'd0, 64'd10, 64'd1000));
        pending_commands.push_back(validate_cmd(1, '1, '1 - 64'd3, 64'd1000));
        pending_commands.push_back(validate_cmd(0, 64'd0, 64'd0, '1));
        pending_commands.push_back(validate_cmd(2, 64'd0, 64'd10, 64'd500));
        pending_commands.push_back(control_cmd(OP_CLEAR, pool_hi[2], pool_lo[2]));
        pending_commands.push_back(control_cmd(OP_CLEAR, pool_hi[2], pool_lo[2]));
        pending_commands.push_back(control_cmd(OP_RESET_STATS, pool_hi[3], pool_lo[3]));
        pending_commands.push_back(control_cmd(OP_UNUSED, pool_hi[1], pool_lo[1]));
        pending_commands.push_back(validate_cmd(3, '1, '1, 64'd0));
        wait_drained();

        // tightest tick window and a one-command rate
        apply_limits(16'd0, 16'd0, 16'd1, 16'd1000);
        @(negedge clk);
        pending_commands.push_back(validate_cmd(1, 64'd5, 64'd5, 64'd2000));
        pending_commands.push_back(validate_cmd(1, 64'd5, 64'd5, 64'd2001));
        pending_commands.push_back(validate_cmd(1, 64'd4, 64'd5, 64'd2002));
        pending_commands.push_back(validate_cmd(1, 64'd6, 64'd5, 64'd2003));
        wait_drained();

        // zero window rejects every command reaching the limiter
        apply_limits(16'd60, 16'd10, 16'd5, 16'd0);
        @(negedge clk);
        pending_commands.push_back(validate_cmd(1, 64'd5, 64'd5, 64'd3000));
        pending_commands.push_back(validate_cmd(1, 64'd5, 64'd5, 64'd3000));
        wait_drained();

        apply_limits(16'd60, 16'd10, 16'd3, 16'd1000);
        hold_requests++;
        run_phase(0, 0, 1'b0);
        apply_limits(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        run_phase(72, 0, 1'b1);
        apply_limits(16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
        run_phase(0, 72, 1'b0);
        apply_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(1, 8)), 16'($urandom_range(1, 3000)));
        run_phase(31, 31, 1'b1);
        apply_limits(16'd100, 16'd100, 16'd2, 16'd500);
        hold_requests++;
        run_phase(0, 0, 1'b0);
        apply_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)));
        run_phase(72, 72, 1'b1);

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
